@@ hw/rtl/tsrc_pkg.sv @@
// Shared constants, types and helpers of the triangle setup block.
`default_nettype none
package tsrc_pkg;

    localparam int DATA_W        = 32;
    localparam int REG_W         = 13;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_VERT      = 3;
    localparam int IN_FIELDS     = 4;
    localparam int OUT_FIELDS    = 3;
    localparam int IN_DATA_W     = NUM_VERT * IN_FIELDS * DATA_W;
    localparam int OUT_DATA_W    = NUM_VERT * OUT_FIELDS * DATA_W;
    localparam int USER_W        = 2;

    // divider lane: magnitude stage, setup stage, one stage per quotient bit, sign stage
    localparam int DIV_LAT  = DATA_W + 2;
    localparam int VIEW_LAT = 5;
    localparam int PIPE_LAT = DIV_LAT + VIEW_LAT;

    localparam logic [REG_W-1:0] WIDTH_RST  = REG_W'(800);
    localparam logic [REG_W-1:0] HEIGHT_RST = REG_W'(600);

    typedef enum logic {
        REG_SCR_W = 1'b0,
        REG_SCR_H = 1'b1
    } t_reg_idx;

    localparam logic [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // result flags, tuser layout: rejected in bit 0, back_facing in bit 1
    typedef struct packed {
        logic back_facing;
        logic rejected;
    } t_flags;

    function automatic logic [DATA_W-1:0] sat32(input logic signed [47:0] v);
        logic [DATA_W-1:0] r;
        if (v > $signed(48'(S32_MAX)))
            r = S32_MAX;
        else if (v < -$signed(48'(S32_MAX)) - 48'sd1)
            r = S32_MIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/tsrc_div.sv @@
// Pipelined signed Q divide lane: (v << FRAC_BITS) / w, one quotient bit per stage.
`default_nettype none
module tsrc_div #(
    parameter int FRAC_BITS = tsrc_pkg::FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire [tsrc_pkg::DATA_W-1:0]   i_v,
    input  wire [tsrc_pkg::DATA_W-1:0]   i_w,
    output logic [tsrc_pkg::DATA_W-1:0]  o_q
);
    import tsrc_pkg::*;

    localparam int DW = DATA_W + FRAC_BITS;
    localparam int QW = DATA_W - 1;

    logic [DATA_W-1:0] r0_vm, r0_wm, r0_v;
    logic              r0_neg, r0_wz;

    logic [DATA_W-1:0] r_rem [0:QW];
    logic [QW-1:0]     r_low [0:QW];
    logic [QW-1:0]     r_q   [0:QW];
    logic [DATA_W-1:0] r_d   [0:QW];
    logic [DATA_W-1:0] r_v   [0:QW];
    logic              r_neg [0:QW];
    logic              r_wz  [0:QW];
    logic              r_ovf [0:QW];

    logic [DW-1:0]       dvd;
    logic [DW-QW-1:0]    dvd_top;
    logic [DATA_W-1:0]   n_q;

    // magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_vm  <= i_v[DATA_W-1] ? DATA_W'(-i_v) : i_v;
            r0_wm  <= i_w[DATA_W-1] ? DATA_W'(-i_w) : i_w;
            r0_neg <= i_v[DATA_W-1] ^ i_w[DATA_W-1];
            r0_wz  <= (i_w == '0);
            r0_v   <= i_v;
        end
    end

    // quotient overflows 31 bits exactly when the top bits already reach the divisor
    assign dvd     = {r0_vm, {FRAC_BITS{1'b0}}};
    assign dvd_top = dvd[DW-1:QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DATA_W'(dvd_top);
            r_low[0] <= dvd[QW-1:0];
            r_q[0]   <= '0;
            r_d[0]   <= r0_wm;
            r_v[0]   <= r0_v;
            r_neg[0] <= r0_neg;
            r_wz[0]  <= r0_wz;
            r_ovf[0] <= (DATA_W'(dvd_top) >= r0_wm);
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_bit
        logic [DATA_W:0] t;
        logic            ge;
        assign t  = {r_rem[k], r_low[k][QW-1]};
        assign ge = (t >= {1'b0, r_d[k]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? DATA_W'(t - {1'b0, r_d[k]}) : t[DATA_W-1:0];
                r_low[k+1] <= r_low[k] << 1;
                r_q[k+1]   <= {r_q[k][QW-2:0], ge};
                r_d[k+1]   <= r_d[k];
                r_v[k+1]   <= r_v[k];
                r_neg[k+1] <= r_neg[k];
                r_wz[k+1]  <= r_wz[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    always_comb begin
        if (r_wz[QW])
            n_q = r_v[QW];
        else if (r_ovf[QW])
            n_q = r_neg[QW] ? S32_MIN : S32_MAX;
        else if (r_neg[QW])
            n_q = DATA_W'(-{1'b0, r_q[QW]});
        else
            n_q = {1'b0, r_q[QW]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= n_q;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/tsrc_view.sv @@
// Viewport mapping and back-face area test, five register stages.
`default_nettype none
module tsrc_view #(
    parameter int FRAC_BITS = tsrc_pkg::FRAC_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_en,
    input  wire [tsrc_pkg::REG_W-1:0]            i_scr_w,
    input  wire [tsrc_pkg::REG_W-1:0]            i_scr_h,
    input  wire [2:0][tsrc_pkg::DATA_W-1:0]      i_nx,
    input  wire [2:0][tsrc_pkg::DATA_W-1:0]      i_ny,
    input  wire [2:0][tsrc_pkg::DATA_W-1:0]      i_nz,
    output logic [2:0][tsrc_pkg::DATA_W-1:0]     o_sx,
    output logic [2:0][tsrc_pkg::DATA_W-1:0]     o_sy,
    output logic [2:0][tsrc_pkg::DATA_W-1:0]     o_sz,
    output logic                                 o_back
);
    import tsrc_pkg::*;

    localparam int PW = DATA_W + REG_W + 1;

    logic signed [PW-1:0]   r1_px [3];
    logic signed [PW-1:0]   r1_py [3];
    logic [DATA_W-1:0]      r1_sz [3];
    logic [DATA_W-1:0]      r2_sx [3], r2_sy [3], r2_sz [3];
    logic signed [DATA_W:0] r3_dx1, r3_dy1, r3_dx2, r3_dy2;
    logic [DATA_W-1:0]      r3_sx [3], r3_sy [3], r3_sz [3];
    logic signed [2*DATA_W+1:0] r4_p1, r4_p2;
    logic [DATA_W-1:0]      r4_sx [3], r4_sy [3], r4_sz [3];

    logic signed [47:0] half_w, half_h;

    assign half_w = $signed(48'(i_scr_w[REG_W-1:1]) << FRAC_BITS);
    assign half_h = $signed(48'(i_scr_h[REG_W-1:1]) << FRAC_BITS);

    for (genvar i = 0; i < 3; i++) begin : g_vert
        logic signed [PW-1:0] hx, hy;
        // halve with truncation toward zero
        assign hx = (r1_px[i] + $signed(PW'(r1_px[i][PW-1]))) >>> 1;
        assign hy = (r1_py[i] + $signed(PW'(r1_py[i][PW-1]))) >>> 1;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r1_px[i] <= PW'($signed(i_nx[i]) * $signed({1'b0, i_scr_w}));
                r1_py[i] <= PW'($signed(i_ny[i]) * $signed({1'b0, i_scr_h}));
                r1_sz[i] <= i_nz[i];
                r2_sx[i] <= sat32(half_w + 48'(hx));
                r2_sy[i] <= sat32(half_h - 48'(hy));
                r2_sz[i] <= r1_sz[i];
                r3_sx[i] <= r2_sx[i];
                r3_sy[i] <= r2_sy[i];
                r3_sz[i] <= r2_sz[i];
                r4_sx[i] <= r3_sx[i];
                r4_sy[i] <= r3_sy[i];
                r4_sz[i] <= r3_sz[i];
                o_sx[i]  <= r4_sx[i];
                o_sy[i]  <= r4_sy[i];
                o_sz[i]  <= r4_sz[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_dx1 <= $signed({r2_sx[1][DATA_W-1], r2_sx[1]})
                    - $signed({r2_sx[0][DATA_W-1], r2_sx[0]});
            r3_dy1 <= $signed({r2_sy[1][DATA_W-1], r2_sy[1]})
                    - $signed({r2_sy[0][DATA_W-1], r2_sy[0]});
            r3_dx2 <= $signed({r2_sx[2][DATA_W-1], r2_sx[2]})
                    - $signed({r2_sx[0][DATA_W-1], r2_sx[0]});
            r3_dy2 <= $signed({r2_sy[2][DATA_W-1], r2_sy[2]})
                    - $signed({r2_sy[0][DATA_W-1], r2_sy[0]});
            r4_p1  <= r3_dx2 * r3_dy1;
            r4_p2  <= r3_dy2 * r3_dx1;
            o_back <= (r4_p1 < r4_p2);
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/tsrc_skid.sv @@
// Output register with one skid entry; upstream ready depends on registers only.
`default_nettype none
module tsrc_skid #(
    parameter int WIDTH = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire [WIDTH-1:0]  i_data,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [WIDTH-1:0] o_data
);
    logic             r_ovld, r_svld;
    logic [WIDTH-1:0] r_odata, r_sdata;
    logic             out_free;

    assign o_ready  = ~r_svld;
    assign out_free = i_ready | ~r_ovld;
    assign o_valid  = r_ovld;
    assign o_data   = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_svld <= 1'b0;
        end else if (i_valid && !r_svld) begin
            if (out_free) begin
                r_odata <= i_data;
                r_ovld  <= 1'b1;
            end else begin
                r_sdata <= i_data;
                r_svld  <= 1'b1;
            end
        end else if (out_free) begin
            if (r_svld) begin
                r_odata <= r_sdata;
                r_ovld  <= 1'b1;
                r_svld  <= 1'b0;
            end else begin
                r_ovld  <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/triangle_setup_reject_cull.sv @@
// Triangle setup top level: trivial reject, perspective divide, viewport map, back-face test.
//
//  channel  | signals                        | beat holds
//  ---------+--------------------------------+-------------------------------------------
//  in       | s_axis_tvalid/tready/tdata     | one triangle, 3 vertices x (x,y,z,w) Q16.16
//  out      | m_axis_tvalid/tready/tdata/user| 3 vertices x (sx,sy,sz), rejected, back_facing
//  cfg      | i_cfg_we/i_cfg_idx/i_cfg_data  | screen width (0), screen height (1)
//
// One triangle per cycle sustained while the output does not stall. On its way out,
// the input beat lands in the input register, then 34-stage divide lanes (31 of them one
// quotient bit each), 5 viewport/area stages and the output register. The bit-serial
// divide pipeline sets the depth.
// Synchronous active-low reset clears valid bits and restores 800 x 600.
// A stall on the output fills a single skid entry, then holds the whole pipeline.
`default_nettype none
module triangle_setup_reject_cull #(
    parameter int FRAC_BITS = tsrc_pkg::FRAC_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // cfg
    input  wire                               i_cfg_we,
    input  wire                               i_cfg_idx,
    input  wire [tsrc_pkg::REG_W-1:0]         i_cfg_data,
    // in: a_x a_y a_z a_w b_x b_y b_z b_w c_x c_y c_z c_w, 32 bits each from bit 0
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire [tsrc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // out: a_sx a_sy a_sz b_sx b_sy b_sz c_sx c_sy c_sz, 32 bits each from bit 0
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [tsrc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // user: rejected (bit 0), back_facing (bit 1)
    output logic [tsrc_pkg::USER_W-1:0]       m_axis_tuser
);
    import tsrc_pkg::*;

    logic [REG_W-1:0] r_scr_w, r_scr_h;

    logic                    en;
    logic                    skid_ready;
    logic [IN_DATA_W-1:0]    r_in;
    logic                    r_vld [0:PIPE_LAT];
    logic                    r_rej [0:PIPE_LAT];

    logic [2:0]              xp, xn, yp, yn, zn;
    logic                    n_rej;

    logic [2:0][DATA_W-1:0]  nx, ny, nz;
    logic [2:0][DATA_W-1:0]  sx, sy, sz;
    logic                    back;
    logic [OUT_DATA_W-1:0]   res_data;
    t_flags                  res_flags;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= WIDTH_RST;
            r_scr_h <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_SCR_W: r_scr_w <= i_cfg_data;
                REG_SCR_H: r_scr_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline advances together; only a full skid entry stops it
    assign en            = skid_ready;
    assign s_axis_tready = en;

    // trivial reject: all three vertices beyond the same plane
    for (genvar i = 0; i < 3; i++) begin : g_rej
        logic signed [DATA_W-1:0] vx, vy, vz, vw;
        assign vx = $signed(s_axis_tdata[(i*IN_FIELDS+0)*DATA_W +: DATA_W]);
        assign vy = $signed(s_axis_tdata[(i*IN_FIELDS+1)*DATA_W +: DATA_W]);
        assign vz = $signed(s_axis_tdata[(i*IN_FIELDS+2)*DATA_W +: DATA_W]);
        assign vw = $signed(s_axis_tdata[(i*IN_FIELDS+3)*DATA_W +: DATA_W]);
        assign xp[i] = vx > vw;
        assign yp[i] = vy > vw;
        // x < -w  <=>  x + w < 0, kept exact in 33 bits
        assign xn[i] = ($signed({vx[DATA_W-1], vx}) + $signed({vw[DATA_W-1], vw})) < 0;
        assign yn[i] = ($signed({vy[DATA_W-1], vy}) + $signed({vw[DATA_W-1], vw})) < 0;
        assign zn[i] = vz[DATA_W-1];
    end

    assign n_rej = (&xp) | (&xn) | (&yp) | (&yn) | (&zn);

    // stage 0: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in     <= s_axis_tdata;
            r_rej[0] <= n_rej;
        end
    end

    // valid and reject flag ride alongside the datapath
    for (genvar s = 0; s < PIPE_LAT; s++) begin : g_ctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rej[s+1] <= r_rej[s];
            end
        end
    end

    // nine divide lanes: x, y, z of each vertex over its w
    for (genvar i = 0; i < 3; i++) begin : g_lane
        logic [DATA_W-1:0] w;
        assign w = r_in[(i*IN_FIELDS+3)*DATA_W +: DATA_W];

        tsrc_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
            .i_clk (i_clk),
            .i_en  (en),
            .i_v   (r_in[(i*IN_FIELDS+0)*DATA_W +: DATA_W]),
            .i_w   (w),
            .o_q   (nx[i])
        );
        tsrc_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
            .i_clk (i_clk),
            .i_en  (en),
            .i_v   (r_in[(i*IN_FIELDS+1)*DATA_W +: DATA_W]),
            .i_w   (w),
            .o_q   (ny[i])
        );
        tsrc_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
            .i_clk (i_clk),
            .i_en  (en),
            .i_v   (r_in[(i*IN_FIELDS+2)*DATA_W +: DATA_W]),
            .i_w   (w),
            .o_q   (nz[i])
        );
    end

    tsrc_view #(.FRAC_BITS(FRAC_BITS)) u_view (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_scr_w (r_scr_w),
        .i_scr_h (r_scr_h),
        .i_nx    (nx),
        .i_ny    (ny),
        .i_nz    (nz),
        .o_sx    (sx),
        .o_sy    (sy),
        .o_sz    (sz),
        .o_back  (back)
    );

    // rejected triangles go out with all coordinates zero
    for (genvar i = 0; i < 3; i++) begin : g_pack
        assign res_data[(i*OUT_FIELDS+0)*DATA_W +: DATA_W] = r_rej[PIPE_LAT] ? '0 : sx[i];
        assign res_data[(i*OUT_FIELDS+1)*DATA_W +: DATA_W] = r_rej[PIPE_LAT] ? '0 : sy[i];
        assign res_data[(i*OUT_FIELDS+2)*DATA_W +: DATA_W] = r_rej[PIPE_LAT] ? '0 : sz[i];
    end

    assign res_flags.rejected    = r_rej[PIPE_LAT];
    assign res_flags.back_facing = back & ~r_rej[PIPE_LAT];

    tsrc_skid #(.WIDTH(OUT_DATA_W + USER_W)) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[PIPE_LAT] & en),
        .o_ready (skid_ready),
        .i_data  ({res_flags, res_data}),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  ({m_axis_tuser, m_axis_tdata})
    );

endmodule
`default_nettype wire

@@ hw/rtl/tsrc_checker.sv @@
// Port-level checks of the triangle setup block, bound to the top level.
`default_nettype none
module tsrc_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_axis_tready,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [tsrc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input wire [tsrc_pkg::USER_W-1:0]       m_axis_tuser
);
    import tsrc_pkg::*;

    // reset empties output and skid
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    // a rejected triangle carries zero coordinates and no back-face mark
    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && (m_axis_tdata == '0))
        else $error("rejected beat carries data");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

endmodule

bind triangle_setup_reject_cull tsrc_checker u_tsrc_checker (.*);
`default_nettype wire

@@ dv/triangle_setup_reject_cull_tb.sv @@
// Self-checking testbench for the triangle setup / trivial reject / back-face cull block.
`timescale 1ns / 1ps
`default_nettype none

// Expected results of the triangle setup block, with its own viewport settings.
class tri_setup_scoreboard;
    typedef struct {
        logic [tsrc_pkg::OUT_DATA_W-1:0] coords;
        tsrc_pkg::t_flags                flags;
    } t_screen_tri;

    t_screen_tri pending_tris[$];
    longint      view_w = 800;
    longint      view_h = 600;
    int          mismatches = 0;

    function void report(string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatches++;
    endfunction

    static function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    static function longint over_w(longint v, longint w);
        if (w == 0) return v;
        return clamp32((v * (64'sd1 <<< tsrc_pkg::FRAC_BITS_DEF)) / w);
    endfunction

    // Predict the screen triangle for one accepted clip-space triangle.
    function void note_triangle(logic [tsrc_pkg::IN_DATA_W-1:0] clip);
        longint x[3], y[3], z[3], w[3], sx[3], sy[3], sz[3];
        longint half_w, half_h;
        logic signed [127:0] e1, e2, e3, e4;
        bit xp, xn, yp, yn, zn;
        t_screen_tri res;
        xp = 1; xn = 1; yp = 1; yn = 1; zn = 1;
        for (int i = 0; i < 3; i++) begin
            x[i] = $signed(clip[(i*4+0)*32 +: 32]);
            y[i] = $signed(clip[(i*4+1)*32 +: 32]);
            z[i] = $signed(clip[(i*4+2)*32 +: 32]);
            w[i] = $signed(clip[(i*4+3)*32 +: 32]);
            xp &= x[i] > w[i];
            xn &= x[i] < -w[i];
            yp &= y[i] > w[i];
            yn &= y[i] < -w[i];
            zn &= z[i] < 0;
        end
        res.coords = '0;
        res.flags  = '0;
        if (xp || xn || yp || yn || zn) begin
            res.flags.rejected = 1'b1;
        end else begin
            half_w = (view_w / 2) * (64'sd1 <<< tsrc_pkg::FRAC_BITS_DEF);
            half_h = (view_h / 2) * (64'sd1 <<< tsrc_pkg::FRAC_BITS_DEF);
            for (int i = 0; i < 3; i++) begin
                sz[i] = over_w(z[i], w[i]);
                sx[i] = clamp32(half_w + (over_w(x[i], w[i]) * view_w) / 2);
                sy[i] = clamp32(half_h - (over_w(y[i], w[i]) * view_h) / 2);
                res.coords[(i*3+0)*32 +: 32] = sx[i][31:0];
                res.coords[(i*3+1)*32 +: 32] = sy[i][31:0];
                res.coords[(i*3+2)*32 +: 32] = sz[i][31:0];
            end
            // exact sign of doubled area, wide enough for 33-bit differences
            e1 = sx[2] - sx[0];
            e2 = sy[1] - sy[0];
            e3 = sy[2] - sy[0];
            e4 = sx[1] - sx[0];
            res.flags.back_facing = (e1 * e2) < (e3 * e4);
        end
        pending_tris.insert(pending_tris.size(), res);
    endfunction

    function void check_result(logic [tsrc_pkg::OUT_DATA_W-1:0] coords,
                               tsrc_pkg::t_flags flags);
        t_screen_tri exp_tri;
        string names[9] = '{"a_sx", "a_sy", "a_sz", "b_sx", "b_sy", "b_sz",
                            "c_sx", "c_sy", "c_sz"};
        if (pending_tris.size() == 0) begin
            report("result beat with no triangle outstanding");
            return;
        end
        exp_tri = pending_tris.pop_front();
        for (int j = 0; j < 9; j++)
            if (coords[j*32 +: 32] !== exp_tri.coords[j*32 +: 32])
                report($sformatf("%s got %h exp %h", names[j], coords[j*32 +: 32],
                                 exp_tri.coords[j*32 +: 32]));
        if (flags.rejected !== exp_tri.flags.rejected)
            report($sformatf("rejected got %b exp %b", flags.rejected,
                             exp_tri.flags.rejected));
        if (flags.back_facing !== exp_tri.flags.back_facing)
            report($sformatf("back_facing got %b exp %b", flags.back_facing,
                             exp_tri.flags.back_facing));
    endfunction
endclass

module triangle_setup_reject_cull_tb;
    import tsrc_pkg::*;

    localparam longint ONE       = 64'sd65536;  // 1.0 in Q16.16
    localparam int     WDOG_MAX  = 5000;        // cycles without any beat
    localparam int     DRAIN_PAD = PIPE_LAT + 10;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic                    i_cfg_idx = 1'b0;
    logic [REG_W-1:0]        i_cfg_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;   // a_x a_y a_z a_w b_x .. c_w
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;        // a_sx a_sy a_sz b_sx .. c_sz
    logic [USER_W-1:0]       m_axis_tuser;        // rejected, back_facing

    tri_setup_scoreboard sb = new();
    bit  no_idle = 0;      // long stretch with both sides always ready
    int  idle_cycles = 0;  // watchdog: cycles with no beat on either side

    triangle_setup_reject_cull dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Receiver back-pressure, ~11% of cycles stalled.
    always @(negedge i_clk)
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 11);

    // Result check and watchdog, sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, t_flags'(m_axis_tuser));
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("watchdog: no beat for %0d cycles", WDOG_MAX);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_tri(longint v[12]);
        logic [IN_DATA_W-1:0] d;
        for (int k = 0; k < 12; k++)
            d[k*32 +: 32] = v[k][31:0];
        return d;
    endfunction

    // Signed value drawn from [lo, hi]; span stays below 2^32.
    function automatic longint srand(longint lo, longint hi);
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_tri();
        longint v[12], w, m;
        int kind, plane;
        kind  = $urandom_range(0, 99);
        plane = $urandom_range(0, 4);
        for (int i = 0; i < 3; i++) begin
            w = srand(1 << 10, 1 << 21);
            v[i*4+3] = w;
            if (kind < 60) begin
                // inside the frustum: mostly visible triangles
                v[i*4+0] = srand(-w, w);
                v[i*4+1] = srand(-w, w);
                v[i*4+2] = srand(0, w);
            end else if (kind < 75) begin
                // all three vertices beyond one plane
                m = srand(1, 1 << 20);
                v[i*4+0] = srand(-w, w);
                v[i*4+1] = srand(-w, w);
                v[i*4+2] = srand(-w, w);
                case (plane)
                    0: v[i*4+0] = w + m;
                    1: v[i*4+0] = -w - m;
                    2: v[i*4+1] = w + m;
                    3: v[i*4+1] = -w - m;
                    default: v[i*4+2] = -m;
                endcase
            end else if (kind < 85) begin
                // zero, tiny or negative w; large coordinates
                v[i*4+3] = ($urandom_range(0, 2) == 0) ? 0 : srand(-256, 256);
                for (int k = 0; k < 3; k++)
                    v[i*4+k] = srand(-(64'sd1 <<< 30), 64'sd1 <<< 30);
            end else begin
                for (int k = 0; k < 4; k++)
                    v[i*4+k] = longint'($signed($urandom()));
            end
        end
        return pack_tri(v);
    endfunction

    // Drive one triangle; returns once the beat is accepted.
    task automatic send_tri(logic [IN_DATA_W-1:0] clip);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 11) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = clip;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_triangle(clip);
    endtask

    // Hold the sender until every outstanding triangle has come back.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_tris.size() != 0) @(posedge i_clk);
    endtask

    // Register write; only called with the pipeline empty.
    task automatic write_reg(t_reg_idx idx, logic [REG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx == REG_SCR_W) sb.view_w = val;
        else sb.view_h = val;
    endtask

    longint mx = 64'sd2147483647;
    longint mn = -64'sd2147483648;
    logic [REG_W-1:0] widths[6]  = '{13'd0, 13'd8191, 13'd1, 13'd4096, 13'd800, 13'd0};
    logic [REG_W-1:0] heights[6] = '{13'd0, 13'd8191, 13'd1, 13'd4096, 13'd600, 13'd0};

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed triangles at reset viewport (800 x 600).
        send_tri(pack_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));           // all zero, w zero
        send_tri(pack_tri('{0, 0, 0, ONE, ONE/2, 0, 0, ONE, 0, ONE/2, 0, ONE}));
        send_tri(pack_tri('{0, 0, 0, ONE, 0, ONE/2, 0, ONE, ONE/2, 0, 0, ONE})); // winding swapped
        send_tri(pack_tri('{2*ONE, 0, 0, ONE, 3*ONE, 0, 0, ONE, 5*ONE, 0, 0, ONE}));  // x > w
        send_tri(pack_tri('{-2*ONE, 0, 0, ONE, -3*ONE, 0, 0, ONE, -ONE-1, 0, 0, ONE})); // x < -w
        send_tri(pack_tri('{0, 2*ONE, 0, ONE, 0, 3*ONE, 0, ONE, 0, ONE+1, 0, ONE}));  // y > w
        send_tri(pack_tri('{0, -2*ONE, 0, ONE, 0, -3*ONE, 0, ONE, 0, -ONE-1, 0, ONE})); // y < -w
        send_tri(pack_tri('{0, 0, -1, ONE, 0, 0, -ONE, ONE, 0, 0, mn, ONE}));        // z < 0
        send_tri(pack_tri('{ONE, -ONE, ONE, 0, 3, 5, 7, 0, -9, 11, 13, 0}));        // zero w
        send_tri(pack_tri('{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx}));
        send_tri(pack_tri('{mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn}));
        send_tri(pack_tri('{mx, mn, mx, 1, mn, mx, 0, 1, 0, 0, 1, 1}));  // divide saturates
        send_tri(pack_tri('{ONE, ONE, ONE, -1, -ONE, 0, ONE, -1, 0, ONE, 0, -1}));   // w negative
        send_tri(pack_tri('{mx, mn, 0, mn, mn, mx, 0, mx, 0, 0, mx, mn}));
        send_tri(pack_tri('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1}));
        send_tri(pack_tri('{2*ONE, 0, 0, ONE, 3*ONE, 0, 0, ONE, 0, 0, 0, ONE}));     // partial
        send_tri(pack_tri('{ONE/3, ONE/3, 0, ONE, ONE/3, ONE/3, 0, ONE, 0, 0, 0, ONE})); // degenerate
        drain();

        // Random triangles across several viewport settings, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_SCR_W,
                      (ph == 5) ? REG_W'($urandom_range(1, 4096)) : widths[ph]);
            write_reg(REG_SCR_H,
                      (ph == 5) ? REG_W'($urandom_range(1, 4096)) : heights[ph]);
            for (int n = 0; n < 292; n++) begin
                no_idle = (ph == 2) && (n >= 40) && (n < 240);
                send_tri(random_tri());
            end
            no_idle = 0;
            drain();
        end

        repeat (DRAIN_PAD) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_tris.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

`default_nettype wire
